FILE: rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg: shared types and constants of the circular FIFO queue
// Word formats of the command and result channels, operation codes and the
// default sizes that the top level hands down.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int WORD_W = 32;
  localparam int CAP_W  = 11;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  // Operation codes; any other code behaves as a query.
  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_DEQ   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

  // Flags settled when the command is taken, held until the result leaves.
  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
  } status_t;

endpackage

FILE: rtl/circular_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_top: ring-buffer FIFO of 32-bit signed words
// Enqueue, dequeue and query commands against a queue whose usable size is
// set by the capacity register; every command returns one result word.
//
//   channel   direction  handshake            word
//   command   in         start, busy          item   (func, value)
//   result    out        done (strobe)        result (ok, front, rear, flags)
//   config    in         cfg_valid, cfg_ready cfg_data (capacity)
//
// A command is taken when start is high and busy is low; its result appears
// on the result port, marked by done, in the response state that follows the read state.
// Busy is high for the one cycle in which the memory reads the front and rear
// entries; a new command can be taken while the previous result is shown.
// The receiver cannot stall; each result is valid only while done is high.
// Reset clears the pointers and the count and sets the capacity to 1024;
// a capacity write, taken only while busy and start are low, empties the queue.
// The memory is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_queue_top #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cfq_pkg::item_t             item,
  output logic                       done,
  output cfq_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cfq_pkg::CAP_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr_front, rd_addr_rear;
  logic [cfq_pkg::WORD_W-1:0] wr_data, rd_front, rd_rear;
  cfq_pkg::status_t           status;

  cfq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .busy          (busy),
    .done          (done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr_front (rd_addr_front),
    .rd_addr_rear  (rd_addr_rear),
    .status        (status)
  );

  cfq_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_front),
    .rd_addr_b (rd_addr_rear),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  // An empty queue reports all-ones for both the front and the rear word.
  always_comb begin
    result.ok         = status.ok;
    result.is_empty   = status.is_empty;
    result.is_full    = status.is_full;
    result.front_word = status.is_empty ? cfq_pkg::EMPTY_WORD : rd_front;
    result.rear_word  = status.is_empty ? cfq_pkg::EMPTY_WORD : rd_rear;
  end

endmodule

FILE: rtl/cfq_mem.sv
// ----------------------------------------------------------------------------
// cfq_mem: storage of the circular FIFO queue
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module cfq_mem #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [cfq_pkg::WORD_W-1:0]    wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_b,
  output logic [cfq_pkg::WORD_W-1:0]    rd_data_a,
  output logic [cfq_pkg::WORD_W-1:0]    rd_data_b
);

  logic [cfq_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: rtl/cfq_ctrl.sv
// ----------------------------------------------------------------------------
// cfq_ctrl: pointer and sequencing logic of the circular FIFO queue
// Applies each command to the pointers and the count, writes the enqueued
// word, then reads the front and rear entries back for the result.
// ----------------------------------------------------------------------------
module cfq_ctrl #(
  parameter int DEPTH = cfq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  cfq_pkg::item_t              item,
  output logic                        busy,
  output logic                        done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cfq_pkg::CAP_W-1:0]   cfg_data,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [cfq_pkg::WORD_W-1:0]  wr_data,
  output logic                        rd_en,
  output logic [$clog2(DEPTH)-1:0]    rd_addr_front,
  output logic [$clog2(DEPTH)-1:0]    rd_addr_rear,
  output cfq_pkg::status_t            status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (cfq_pkg::CAP_W > CW) ? cfq_pkg::CAP_W : CW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESP
  } state_t;

  state_t                    state;
  logic [cfq_pkg::CAP_W-1:0] capacity;
  logic [AW-1:0]             read_pointer, read_pointer_next;
  logic [AW-1:0]             write_pointer, write_pointer_next;
  logic [CW-1:0]             entry_count, entry_count_next;
  logic [CW-1:0]             eff_cap;
  logic [EW-1:0]             cap_ext;
  logic [CW-1:0]             rp_inc, wp_inc;
  logic                      accept, cfg_write, do_enq, do_deq;

  assign accept    = start && !busy;
  // A capacity write is held off while a command is offered, so the two
  // never meet at the same edge.
  assign cfg_ready = !busy && !start;
  assign cfg_write = cfg_valid && cfg_ready;
  assign busy      = (state == S_READ);
  assign done      = (state == S_RESP);

  // A capacity of zero behaves as one, and anything above the depth as the depth.
  assign cap_ext = EW'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_ext);
    end
  end

  assign rp_inc = CW'(read_pointer) + CW'(1);
  assign wp_inc = CW'(write_pointer) + CW'(1);

  assign do_enq = (item.func == cfq_pkg::FUNC_ENQ) && (entry_count < eff_cap);
  assign do_deq = (item.func == cfq_pkg::FUNC_DEQ) && (entry_count != '0);

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    entry_count_next   = entry_count;
    if (do_enq) begin
      write_pointer_next = (wp_inc >= eff_cap) ? '0 : AW'(wp_inc);
      entry_count_next   = entry_count + CW'(1);
    end
    if (do_deq) begin
      read_pointer_next = (rp_inc >= eff_cap) ? '0 : AW'(rp_inc);
      entry_count_next  = entry_count - CW'(1);
    end
  end

  assign wr_en   = accept && do_enq;
  assign wr_addr = write_pointer;
  assign wr_data = item.value;

  // The reads are issued in the read state, after the write has taken effect, so a word just enqueued
  // is already in the memory when it is read back.
  assign rd_en         = (state == S_READ);
  assign rd_addr_front = read_pointer;
  assign rd_addr_rear  = (write_pointer == '0) ? AW'(eff_cap - CW'(1))
                                               : write_pointer - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= cfq_pkg::CAP_RESET;
      read_pointer  <= '0;
      write_pointer <= '0;
      entry_count   <= '0;
      status        <= '0;
    end else begin
      case (state)
        S_IDLE:  state <= accept ? S_READ : S_IDLE;
        S_READ:  state <= S_RESP;
        S_RESP:  state <= accept ? S_READ : S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cfg_write) begin
        // A new capacity empties the queue.
        capacity      <= cfg_data;
        read_pointer  <= '0;
        write_pointer <= '0;
        entry_count   <= '0;
      end else if (accept) begin
        read_pointer  <= read_pointer_next;
        write_pointer <= write_pointer_next;
        entry_count   <= entry_count_next;
      end
      if (accept) begin
        status.ok       <= !(((item.func == cfq_pkg::FUNC_ENQ) && !do_enq) ||
                             ((item.func == cfq_pkg::FUNC_DEQ) && !do_deq));
        status.is_empty <= (entry_count_next == '0);
        status.is_full  <= (entry_count_next >= eff_cap);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= eff_cap)
    else $error("entry count exceeds capacity");

  a_empty_pointers: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> (read_pointer == write_pointer))
    else $error("empty queue with pointers apart");

  a_read_then_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> done)
    else $error("result missing after memory read");

  a_enq_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_write && do_enq) |=> (entry_count == $past(entry_count) + CW'(1)))
    else $error("accepted enqueue did not raise the count");
`endif

endmodule

FILE: sim/tb_circular_fifo_queue_top.sv
// ----------------------------------------------------------------------------
// tb_circular_fifo_queue_top: self-checking bench for the circular FIFO queue
// Drives enqueue, dequeue and query words through the start/busy command
// port. Capacity settings across the register range are tried, from zero to
// its largest value. A scoreboard keeps its own model of the ring and compares
// every result word with its prediction. Commands come in bursts with random
// gaps, and a watchdog ends the run if the traffic stops.
// ----------------------------------------------------------------------------
module tb_circular_fifo_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = cfq_pkg::DEPTH_DEFAULT;
  localparam int WORD_W       = cfq_pkg::WORD_W;
  localparam int CAP_W        = cfq_pkg::CAP_W;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int REPORT_LIMIT = 10;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_BURST    = 16;
  localparam int MAX_GAP      = 12;

  // The fourth selector code has no name in the package and acts as a query.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  cfq_pkg::item_t   item      = '0;
  logic             done;
  cfq_pkg::result_t result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = '0;

  int idle_cycles = 0;

  class fifo_queue_scoreboard;
    logic [WORD_W-1:0] words [DEPTH];
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [CAP_W-1:0]  fill;
    logic [CAP_W-1:0]  cap_reg;
    cfq_pkg::result_t  expected_results [$];
    int                mismatches;

    function new();
      cap_reg    = cfq_pkg::CAP_RESET;
      head       = '0;
      tail       = '0;
      fill       = '0;
      mismatches = 0;
    endfunction

    // A capacity write also empties the queue.
    function void write_capacity(logic [CAP_W-1:0] value);
      cap_reg = value;
      head    = '0;
      tail    = '0;
      fill    = '0;
    endfunction

    function logic [CAP_W-1:0] usable_capacity();
      if (cap_reg == '0) return CAP_W'(1);
      if (cap_reg > CAP_W'(DEPTH)) return CAP_W'(DEPTH);
      return cap_reg;
    endfunction

    // Pointers wrap at the usable capacity, not at the built depth.
    function logic [PTR_W-1:0] advance(logic [PTR_W-1:0] ptr, logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] next;
      next = CAP_W'(ptr) + CAP_W'(1);
      return (next >= cap) ? '0 : next[PTR_W-1:0];
    endfunction

    function void note_command(cfq_pkg::item_t cmd);
      cfq_pkg::result_t pred;
      logic [CAP_W-1:0] cap;
      logic [PTR_W-1:0] last;
      cap             = usable_capacity();
      pred.ok         = 1'b1;
      pred.front_word = cfq_pkg::EMPTY_WORD;
      pred.rear_word  = cfq_pkg::EMPTY_WORD;
      case (cmd.func)
        cfq_pkg::FUNC_ENQ: begin
          if (fill < cap) begin
            words[tail] = cmd.value;
            tail        = advance(tail, cap);
            fill        = fill + 1'b1;
          end else begin
            pred.ok = 1'b0;
          end
        end
        cfq_pkg::FUNC_DEQ: begin
          if (fill != '0) begin
            head = advance(head, cap);
            fill = fill - 1'b1;
          end else begin
            pred.ok = 1'b0;
          end
        end
        default: ;
      endcase
      if (fill != '0) begin
        last            = (tail == '0) ? PTR_W'(cap - 1'b1) : tail - 1'b1;
        pred.front_word = words[head];
        pred.rear_word  = words[last];
      end
      pred.is_empty = (fill == '0);
      pred.is_full  = (fill >= cap);
      expected_results.push_back(pred);
    endfunction

    function void check_result(cfq_pkg::result_t got);
      cfq_pkg::result_t pred;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result word with no command outstanding: ok=%b front=%0d rear=%0d",
                   $time, got.ok, got.front_word, got.rear_word);
        return;
      end
      pred = expected_results.pop_front();
      if (got.ok !== pred.ok || got.front_word !== pred.front_word ||
          got.rear_word !== pred.rear_word || got.is_empty !== pred.is_empty ||
          got.is_full !== pred.is_full) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: expected ok=%b front=%0d rear=%0d empty=%b full=%b",
                   $time, pred.ok, pred.front_word, pred.rear_word, pred.is_empty,
                   pred.is_full);
          $display("%0t:      got ok=%b front=%0d rear=%0d empty=%b full=%b",
                   $time, got.ok, got.front_word, got.rear_word, got.is_empty,
                   got.is_full);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int failures();
      return mismatches + expected_results.size();
    endfunction
  endclass

  fifo_queue_scoreboard sb;

  circular_fifo_queue_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Values read here are those from before the edge, as the block saw them.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_command(item);
      if (cfg_valid && cfg_ready) sb.write_capacity(cfg_data);
      if (done || (start && !busy) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_command(input cfq_pkg::item_t cmd);
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_op(input logic [1:0] op, input logic signed [WORD_W-1:0] value);
    cfq_pkg::item_t cmd;
    cmd.func  = op;
    cmd.value = value;
    send_command(cmd);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic configure(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return cfq_pkg::EMPTY_WORD;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cfq_pkg::item_t random_command(input int enq_pct);
    cfq_pkg::item_t cmd;
    int             roll;
    roll      = $urandom_range(0, 99);
    cmd.value = pick_value();
    if (roll < enq_pct)
      cmd.func = cfq_pkg::FUNC_ENQ;
    else if (roll < enq_pct + (100 - enq_pct) * 3 / 4)
      cmd.func = cfq_pkg::FUNC_DEQ;
    else
      cmd.func = ($urandom_range(0, 3) == 0) ? FUNC_SPARE : cfq_pkg::FUNC_QUERY;
    return cmd;
  endfunction

  // Bursts of random length; about one burst in four runs straight on.
  task automatic run_traffic(input int count, input int enq_pct);
    int burst_left;
    int sent;
    burst_left = $urandom_range(1, MAX_BURST);
    for (sent = 0; sent < count; sent++) begin
      send_command(random_command(enq_pct));
      burst_left--;
      if (sent == count / 2) begin
        wait_drained();
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, MAX_BURST);
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, MAX_GAP));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: empty-queue cases, the extreme words and the spare code.
    send_op(cfq_pkg::FUNC_QUERY, pick_value());
    send_op(cfq_pkg::FUNC_DEQ, pick_value());
    send_op(FUNC_SPARE, pick_value());
    send_op(cfq_pkg::FUNC_ENQ, WORD_MAX);
    send_op(cfq_pkg::FUNC_ENQ, WORD_MIN);
    send_op(cfq_pkg::FUNC_ENQ, cfq_pkg::EMPTY_WORD);
    send_op(cfq_pkg::FUNC_ENQ, '0);
    send_op(cfq_pkg::FUNC_QUERY, pick_value());
    repeat (4) send_op(cfq_pkg::FUNC_DEQ, pick_value());
    send_op(cfq_pkg::FUNC_DEQ, pick_value());

    // A capacity of zero behaves as one.
    configure('0);
    send_op(cfq_pkg::FUNC_ENQ, pick_value());
    send_op(cfq_pkg::FUNC_ENQ, pick_value());
    send_op(cfq_pkg::FUNC_QUERY, pick_value());
    send_op(cfq_pkg::FUNC_DEQ, pick_value());
    send_op(cfq_pkg::FUNC_DEQ, pick_value());

    // Two entries: full refusal and both pointers wrapping.
    configure(CAP_W'(2));
    repeat (3) send_op(cfq_pkg::FUNC_ENQ, pick_value());
    send_op(cfq_pkg::FUNC_DEQ, pick_value());
    send_op(cfq_pkg::FUNC_ENQ, pick_value());
    send_op(FUNC_SPARE, pick_value());
    repeat (2) send_op(cfq_pkg::FUNC_DEQ, pick_value());

    configure(CAP_W'(1));
    run_traffic(60, 50);
    configure(CAP_W'(3));
    run_traffic(60, 50);
    configure(CAP_W'(7));
    run_traffic(60, 60);
    configure(CAP_W'($urandom_range(4, 64)));
    run_traffic(80, 55);
    configure(CAP_W'(DEPTH + 1));
    run_traffic(40, 70);

    // Largest register value: a long run of enqueues, then mixed traffic.
    configure('1);
    run_traffic(360, 100);
    run_traffic(80, 45);

    configure(CAP_W'($urandom_range(1, (1 << CAP_W) - 1)));
    run_traffic(50, 50);
    configure(cfq_pkg::CAP_RESET);
    run_traffic(40, 60);
    configure(CAP_W'($urandom_range(2, 16)));
    run_traffic(100, 50);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: circular_fifo_queue_top.f
rtl/cfq_pkg.sv
rtl/cfq_mem.sv
rtl/cfq_ctrl.sv
rtl/circular_fifo_queue_top.sv
sim/tb_circular_fifo_queue_top.sv
